@@ src/pip_pkg.sv @@
// Shared types for the point-in-polygon tester: item kinds and back-end sequencer states.
`default_nettype none

package pip_pkg;

	// Item kinds on the input queue
	typedef enum logic [1:0] {
		KIND_APPEND = 2'd0,
		KIND_QUERY  = 2'd1,
		KIND_CLEAR  = 2'd2
	} kind_t;

	// Back-end edge walk sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} back_state_t;

	// Fewest vertices that make a polygon
	localparam int unsigned MIN_POLY_VERTICES = 3;

endpackage

`default_nettype wire

@@ src/point_in_polygon_test_top.sv @@
// Top level of the point-in-polygon tester: front end, command queue and edge-walk back end.
//
// Input queue: an item (kind, coord_x, coord_y) is taken at a clock edge with push high and
// full low. Kind 0 appends a vertex, kind 1 queries a point, kind 2 clears, kind 3 is ignored.
// Appends and queries are taken one per cycle while the two-entry command queue has room.
// A clear holds full high until every earlier query has finished reading the vertex store,
// then takes effect.
// Result queue: each query yields one transaction, held on the result ports while empty is
// low and retired at an edge with pop high. A held result stops intake only once the command
// queue fills; the back end starts its next query once the result register is free.
// Edge walk: a query with n >= 3 vertices reads n + 1 vertex store entries, one per cycle;
// with fewer than three vertices the result appears in the cycle after it leaves the command
// queue. The single read port of the vertex store sets the rate of one edge per cycle.
// Reset (arst_n low) empties both queues and the polygon; the box returns to its empty values.
`default_nettype none

module point_in_polygon_test_top #(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_BITS   = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [1:0]            kind,
	input  wire logic [COORD_BITS-1:0] coord_x,
	input  wire logic [COORD_BITS-1:0] coord_y,
	output logic                       empty,
	input  wire logic                  pop,
	output logic                       inside_res,
	output logic [COORD_BITS-1:0]      box_min_x,
	output logic [COORD_BITS-1:0]      box_min_y,
	output logic [COORD_BITS-1:0]      box_max_x,
	output logic [COORD_BITS-1:0]      box_max_y,
	output logic [$clog2(MAX_VERTICES+1)-1:0] vertex_total,
	output logic                       dropped
);

	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int AW = $clog2(MAX_VERTICES);
	localparam int DW = 6 * COORD_BITS + CW + 1;

	logic                    q_push, q_full, q_pop, q_empty;
	logic [DW-1:0]           q_din, q_head;
	logic                    back_busy;
	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic [2*COORD_BITS-1:0] wr_data;

	pip_front #(
		.MAX_VERTICES(MAX_VERTICES),
		.COORD_BITS  (COORD_BITS),
		.CW          (CW),
		.AW          (AW),
		.DW          (DW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.kind     (kind),
		.coord_x  (coord_x),
		.coord_y  (coord_y),
		.q_push   (q_push),
		.q_din    (q_din),
		.q_full   (q_full),
		.q_empty  (q_empty),
		.back_busy(back_busy),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	pip_cmd_fifo #(
		.DW(DW)
	) u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_din),
		.full  (q_full),
		.pop   (q_pop),
		.dout  (q_head),
		.empty (q_empty)
	);

	pip_back #(
		.MAX_VERTICES(MAX_VERTICES),
		.COORD_BITS  (COORD_BITS),
		.CW          (CW),
		.AW          (AW),
		.DW          (DW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.busy        (back_busy),
		.empty       (empty),
		.pop         (pop),
		.inside_res  (inside_res),
		.box_min_x   (box_min_x),
		.box_min_y   (box_min_y),
		.box_max_x   (box_max_x),
		.box_max_y   (box_max_y),
		.vertex_total(vertex_total),
		.dropped     (dropped)
	);

	// An accepted query is waiting in the command queue on the next cycle
	a_query_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && kind == 2'(pip_pkg::KIND_QUERY)) |=> !q_empty)
		else $error("accepted query missing from command queue");

	// The back end only takes commands that exist
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command queue popped while empty");

	// A result that is not taken stays valid
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result lost before pop");

	// Vertex store writes never land while the queue pushes a query in the same cycle
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && q_push))
		else $error("append and query decoded together");

endmodule

`default_nettype wire

@@ src/pip_front.sv @@
// Front end: accepts items, keeps vertex count, bounding box and drop flag, issues queries.
`default_nettype none

module pip_front #(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_BITS   = 16,
	parameter int CW           = 7,
	parameter int AW           = 6,
	parameter int DW           = 6 * 16 + 7 + 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [1:0]            kind,
	input  wire logic [COORD_BITS-1:0] coord_x,
	input  wire logic [COORD_BITS-1:0] coord_y,
	// command queue toward the back end
	output logic                       q_push,
	output logic [DW-1:0]              q_din,
	input  wire logic                  q_full,
	input  wire logic                  q_empty,
	input  wire logic                  back_busy,
	// vertex store write port
	output logic                       wr_en,
	output logic [AW-1:0]              wr_addr,
	output logic [2*COORD_BITS-1:0]    wr_data
);

	localparam logic signed [COORD_BITS-1:0] CoordTop = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] CoordBot = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam logic [CW-1:0] CountMax = CW'(MAX_VERTICES);

	logic [CW-1:0]                count_q;
	logic signed [COORD_BITS-1:0] min_x_q, min_y_q, max_x_q, max_y_q;
	logic                         drop_q;
	logic                         clr_pend_q;
	logic                         clr_go;
	logic                         take;
	logic signed [COORD_BITS-1:0] px, py;

	assign px = $signed(coord_x);
	assign py = $signed(coord_y);

	// A pending clear blocks intake until every earlier query has finished reading
	assign full   = clr_pend_q | q_full;
	assign take   = push & ~full;
	assign clr_go = clr_pend_q & ~back_busy & q_empty;

	// Decode of the accepted transaction
	always_comb begin
		q_push = 1'b0;
		wr_en  = 1'b0;
		unique case (pip_pkg::kind_t'(kind))
			pip_pkg::KIND_APPEND: wr_en  = take & (count_q != CountMax);
			pip_pkg::KIND_QUERY:  q_push = take;
			pip_pkg::KIND_CLEAR:  ;
			default:              ;
		endcase
	end

	assign wr_addr = count_q[AW-1:0];
	assign wr_data = {coord_x, coord_y};
	// query command: point, count snapshot, box, drop flag
	assign q_din   = {coord_x, coord_y, count_q, min_x_q, min_y_q, max_x_q, max_y_q, drop_q};

	// Polygon summary state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			min_x_q    <= CoordTop;
			min_y_q    <= CoordTop;
			max_x_q    <= CoordBot;
			max_y_q    <= CoordBot;
			drop_q     <= 1'b0;
			clr_pend_q <= 1'b0;
		end else if (clr_go) begin
			count_q    <= '0;
			min_x_q    <= CoordTop;
			min_y_q    <= CoordTop;
			max_x_q    <= CoordBot;
			max_y_q    <= CoordBot;
			drop_q     <= 1'b0;
			clr_pend_q <= 1'b0;
		end else if (take) begin
			case (pip_pkg::kind_t'(kind))
				pip_pkg::KIND_APPEND: begin
					if (count_q == CountMax) begin
						drop_q <= 1'b1;
					end else begin
						count_q <= count_q + CW'(1);
						if (px < min_x_q) min_x_q <= px;
						if (px > max_x_q) max_x_q <= px;
						if (py < min_y_q) min_y_q <= py;
						if (py > max_y_q) max_y_q <= py;
					end
				end
				pip_pkg::KIND_CLEAR: clr_pend_q <= 1'b1;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ src/pip_cmd_fifo.sv @@
// Two-entry command queue between front end and back end.
`default_nettype none

module pip_cmd_fifo #(
	parameter int DW = 104
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic [DW-1:0] din,
	output logic               full,
	input  wire logic          pop,
	output logic [DW-1:0]      dout,
	output logic               empty
);

	logic [1:0]    cnt_q;
	logic [DW-1:0] ent0_q, ent1_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = ent0_q;

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Entries; head is always entry 0
	always_ff @(posedge clk) begin
		if (push && pop) begin
			if (cnt_q == 2'd1) begin
				ent0_q <= din;
			end else begin
				ent0_q <= ent1_q;
				ent1_q <= din;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) ent0_q <= din;
			else               ent1_q <= din;
		end else if (pop) begin
			ent0_q <= ent1_q;
		end
	end

endmodule

`default_nettype wire

@@ src/pip_back.sv @@
// Back end: vertex store and pipelined edge walk that counts ray crossings.
`default_nettype none

module pip_back #(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_BITS   = 16,
	parameter int CW           = 7,
	parameter int AW           = 6,
	parameter int DW           = 6 * 16 + 7 + 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// vertex store write port
	input  wire logic                  wr_en,
	input  wire logic [AW-1:0]         wr_addr,
	input  wire logic [2*COORD_BITS-1:0] wr_data,
	// command queue
	input  wire logic                  q_empty,
	input  wire logic [DW-1:0]         q_head,
	output logic                       q_pop,
	output logic                       busy,
	// result queue
	output logic                       empty,
	input  wire logic                  pop,
	output logic                       inside_res,
	output logic [COORD_BITS-1:0]      box_min_x,
	output logic [COORD_BITS-1:0]      box_min_y,
	output logic [COORD_BITS-1:0]      box_max_x,
	output logic [COORD_BITS-1:0]      box_max_y,
	output logic [CW-1:0]              vertex_total,
	output logic                       dropped
);

	localparam int W  = COORD_BITS;
	// box corners and drop flag
	localparam int BW = 4 * W + 1;

	pip_pkg::back_state_t state_q, state_d;

	logic [2*W-1:0] mem_q [MAX_VERTICES];

	// command fields
	logic signed [W-1:0] h_px, h_py;
	logic [CW-1:0]       h_n;
	logic [BW-1:0]       h_box;
	logic signed [W-1:0] px_q, py_q;
	logic [CW-1:0]       n_q;
	logic [BW-1:0]       box_q;

	logic          start;
	logic          short_poly;
	logic          finish;
	logic [CW-1:0] rd_cnt_q;
	logic          rd_last;
	logic [AW-1:0] raddr;

	// stage 1: read data
	logic                v_s1, first_s1, last_s1;
	logic [2*W-1:0]      rdata_s1;
	logic signed [W-1:0] x1, y1, x2, y2;
	logic signed [W-1:0] prev_x_q, prev_y_q;
	logic signed [W:0]   dy, da, dc, dd;
	// stage 2: edge differences
	logic                v_s2, last_s2, strad_s2;
	logic signed [W:0]   a_s2, b_s2, c_s2, d_s2;
	// stage 3: products
	logic                  v_s3, last_s3, strad_s3;
	logic signed [2*W+1:0] pl_s3, pr_s3;
	logic                  hit;
	logic                  par_q;
	logic                  res_vld_q;

	assign {h_px, h_py, h_n, h_box} = q_head;

	assign start      = (state_q == pip_pkg::ST_IDLE) & ~q_empty & ~res_vld_q;
	assign short_poly = (h_n < CW'(pip_pkg::MIN_POLY_VERTICES));
	assign q_pop      = start;
	assign busy       = (state_q != pip_pkg::ST_IDLE);

	// Reads go 0..n-1 then wrap to 0 for the closing edge
	assign rd_last = (rd_cnt_q == n_q);
	assign raddr   = rd_last ? '0 : rd_cnt_q[AW-1:0];
	assign finish  = v_s3 & last_s3;

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pip_pkg::ST_IDLE:  if (start && !short_poly) state_d = pip_pkg::ST_RUN;
			pip_pkg::ST_RUN:   if (rd_last) state_d = pip_pkg::ST_DRAIN;
			pip_pkg::ST_DRAIN: if (finish) state_d = pip_pkg::ST_IDLE;
			default:           state_d = pip_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= pip_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	// Vertex store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		rdata_s1 <= mem_q[raddr];
	end

	// Read counter and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			par_q    <= 1'b0;
		end else begin
			if (start) rd_cnt_q <= '0;
			else if (state_q == pip_pkg::ST_RUN) rd_cnt_q <= rd_cnt_q + CW'(1);
			v_s1 <= (state_q == pip_pkg::ST_RUN);
			v_s2 <= v_s1 & ~first_s1;
			v_s3 <= v_s2;
			if (start)    par_q <= 1'b0;
			else if (hit) par_q <= ~par_q;
		end
	end

	// Command latch and stage tags
	always_ff @(posedge clk) begin
		if (start) begin
			px_q  <= h_px;
			py_q  <= h_py;
			n_q   <= h_n;
			box_q <= h_box;
		end
		first_s1 <= (rd_cnt_q == '0);
		last_s1  <= rd_last;
		last_s2  <= last_s1;
		last_s3  <= last_s2;
	end

	// Stage 1: edge from previous vertex to the one just read
	assign x1 = prev_x_q;
	assign y1 = prev_y_q;
	assign x2 = $signed(rdata_s1[2*W-1:W]);
	assign y2 = $signed(rdata_s1[W-1:0]);
	assign dy = {y2[W-1], y2} - {y1[W-1], y1};
	assign da = {px_q[W-1], px_q} - {x1[W-1], x1};
	assign dc = {x2[W-1], x2} - {x1[W-1], x1};
	// offset of the point from the edge start, signed to match dy
	assign dd = dy[W] ? ({y1[W-1], y1} - {py_q[W-1], py_q})
	                  : ({py_q[W-1], py_q} - {y1[W-1], y1});

	always_ff @(posedge clk) begin
		if (v_s1) begin
			prev_x_q <= x2;
			prev_y_q <= y2;
		end
		strad_s2 <= ((y1 > py_q) != (y2 > py_q));
		a_s2     <= da;
		b_s2     <= dy[W] ? -dy : dy;
		c_s2     <= dc;
		d_s2     <= dd;
	end

	// Stage 2: cross-multiplied ray test operands
	always_ff @(posedge clk) begin
		strad_s3 <= strad_s2;
		pl_s3    <= a_s2 * b_s2;
		pr_s3    <= c_s2 * d_s2;
	end

	// Stage 3: crossing lies strictly right of the point
	assign hit = v_s3 & strad_s3 & (pl_s3 < pr_s3);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if ((start && short_poly) || finish) begin
			res_vld_q <= 1'b1;
		end else if (pop && res_vld_q) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start && short_poly) begin
			inside_res   <= 1'b0;
			vertex_total <= h_n;
			{box_min_x, box_min_y, box_max_x, box_max_y, dropped} <= h_box;
		end else if (finish) begin
			inside_res   <= par_q ^ hit;
			vertex_total <= n_q;
			{box_min_x, box_min_y, box_max_x, box_max_y, dropped} <= box_q;
		end
	end

	assign empty = ~res_vld_q;

endmodule

`default_nettype wire
